FILE: rtl/core/local_history_branch_predictor_defines.svh
// Assertion macros shared by the local history branch predictor RTL.
`ifndef LOCAL_HISTORY_BRANCH_PREDICTOR_DEFINES_SVH
`define LOCAL_HISTORY_BRANCH_PREDICTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LHBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LHBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lhbp_pkg.sv
// Types, sizes and helper functions of the local history branch predictor.
package lhbp_pkg;

	localparam int PC_INDEX_BITS = 12;
	localparam int HISTORY_BITS  = 16;
	localparam int HIST_DEPTH    = 1 << PC_INDEX_BITS;
	localparam int CTR_DEPTH     = 1 << HISTORY_BITS;

	// The clearing sweep covers the larger of the two tables.
	localparam int CLR_BITS  = (PC_INDEX_BITS > HISTORY_BITS) ? PC_INDEX_BITS : HISTORY_BITS;
	localparam int CLR_W     = CLR_BITS + 1;
	localparam int CLR_DEPTH = 1 << CLR_BITS;

	typedef logic [PC_INDEX_BITS-1:0] hidx_t;
	typedef logic [HISTORY_BITS-1:0]  hist_t;
	typedef logic [1:0]               ctr_t;
	typedef logic [CLR_W-1:0]         clr_t;

	localparam ctr_t  CTR_MIN        = 2'd0;
	localparam ctr_t  CTR_MAX        = 2'd3;
	localparam ctr_t  CTR_WEAK_TAKEN = 2'd2;
	localparam ctr_t  CTR_WEAK_NOT   = 2'd1;
	localparam hist_t HIST_RESET     = '1;

	// Result of one table update.
	typedef struct packed {
		logic  we;
		logic  taken;
		ctr_t  ctr;
		hist_t hist;
	} upd_t;

	// Reset value of a counter: lower half weakly taken, upper half weakly not taken.
	function automatic ctr_t ctr_reset(input hist_t idx);
		return idx[HISTORY_BITS-1] ? CTR_WEAK_NOT : CTR_WEAK_TAKEN;
	endfunction

endpackage

FILE: rtl/core/lhbp_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module lhbp_ram #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);

	logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/lhbp_update.sv
// Prediction, saturating counter step and history shift for one item.
module lhbp_update (
	input  logic            kind,
	input  logic            outcome,
	input  lhbp_pkg::ctr_t  ctr,
	input  lhbp_pkg::hist_t hist,
	output lhbp_pkg::upd_t  upd
);

	always_comb begin
		upd.we    = kind;
		upd.taken = ctr[1];
		// Move the counter one step toward the outcome, saturating at both ends.
		if (outcome) begin
			upd.ctr = (ctr == lhbp_pkg::CTR_MAX) ? ctr : ctr + 2'd1;
		end else begin
			upd.ctr = (ctr == lhbp_pkg::CTR_MIN) ? ctr : ctr - 2'd1;
		end
		// Shift the history right and insert the outcome at the top.
		upd.hist = {outcome, hist[lhbp_pkg::HISTORY_BITS-1:1]};
	end

endmodule

FILE: rtl/core/local_history_branch_predictor.sv
// Top level of the two-level local history branch predictor.
//
// Usage: an input item (kind, pc, outcome) is taken on in_valid & in_ready.
// kind 0 only predicts; kind 1 also trains the tables with the outcome.
// Every item gives exactly one result item, predict_taken, on out_valid &
// out_ready; it is the prediction before any update.
// Sequence: the history word is read at the accepting edge, the counter at
// the next edge, and the result is registered from state S_CRD once the
// output register is free, which raises out_valid. One item is in flight at
// a time, so the block takes no new item until the last one is through its
// two chained table reads and its write-back.
// Reset: after arst_n releases, a clearing pass writes every history word
// to all ones and every counter to its start value, one address per cycle.
// It spans the counter table depth, the larger table; in_ready stays low.
// Stall: a waiting result sits in the output register while the next item
// is accepted and its reads proceed; that item holds before its write-back
// until the result ahead of it is taken.
`include "local_history_branch_predictor_defines.svh"

module local_history_branch_predictor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] pc,
	input  logic        outcome,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        predict_taken
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HRD,
		S_CRD
	} state_t;

	state_t           state_q;
	lhbp_pkg::clr_t   clr_q;
	lhbp_pkg::hidx_t  hidx_q;
	lhbp_pkg::hist_t  hist_q;
	logic             kind_q;
	logic             outcome_q;

	logic             in_accept;
	logic             finish;
	logic             clearing;
	lhbp_pkg::hidx_t  clr_hidx;
	lhbp_pkg::hist_t  clr_cidx;

	logic             h_we;
	lhbp_pkg::hidx_t  h_waddr;
	lhbp_pkg::hist_t  h_wdata;
	lhbp_pkg::hist_t  h_rdata;
	logic             c_we;
	lhbp_pkg::hist_t  c_waddr;
	lhbp_pkg::ctr_t   c_wdata;
	lhbp_pkg::ctr_t   c_rdata;
	logic             c_re;
	lhbp_pkg::upd_t   upd;

	// Handshake and phase decode.
	assign clearing  = (state_q == S_CLEAR);
	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign finish    = (state_q == S_CRD) && (!out_valid || out_ready);
	assign c_re      = (state_q == S_HRD);
	assign clr_hidx  = clr_q[lhbp_pkg::PC_INDEX_BITS-1:0];
	assign clr_cidx  = clr_q[lhbp_pkg::HISTORY_BITS-1:0];

	// History table write: clearing sweep or training write-back.
	assign h_we    = clearing ? (clr_q < lhbp_pkg::CLR_W'(lhbp_pkg::HIST_DEPTH))
	                          : (finish && upd.we);
	assign h_waddr = clearing ? clr_hidx : hidx_q;
	assign h_wdata = clearing ? lhbp_pkg::HIST_RESET : upd.hist;

	// Counter table write: clearing sweep or training write-back.
	assign c_we    = clearing ? (clr_q < lhbp_pkg::CLR_W'(lhbp_pkg::CTR_DEPTH))
	                          : (finish && upd.we);
	assign c_waddr = clearing ? clr_cidx : hist_q;
	assign c_wdata = clearing ? lhbp_pkg::ctr_reset(clr_cidx) : upd.ctr;

	lhbp_ram #(
		.ADDR_BITS (lhbp_pkg::PC_INDEX_BITS),
		.DATA_BITS (lhbp_pkg::HISTORY_BITS)
	) u_hist_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.re    (in_accept),
		.raddr (pc[lhbp_pkg::PC_INDEX_BITS-1:0]),
		.rdata (h_rdata)
	);

	lhbp_ram #(
		.ADDR_BITS (lhbp_pkg::HISTORY_BITS),
		.DATA_BITS (2)
	) u_ctr_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (h_rdata),
		.rdata (c_rdata)
	);

	lhbp_update u_update (
		.kind    (kind_q),
		.outcome (outcome_q),
		.ctr     (c_rdata),
		.hist    (hist_q),
		.upd     (upd)
	);

	// Sequencer with the item context and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			hidx_q        <= '0;
			hist_q        <= '0;
			kind_q        <= 1'b0;
			outcome_q     <= 1'b0;
			out_valid     <= 1'b0;
			predict_taken <= 1'b0;
		end else begin
			// A taken result empties the output register unless a new one replaces it.
			if (out_valid && out_ready && !finish) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == lhbp_pkg::CLR_W'(lhbp_pkg::CLR_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						hidx_q    <= pc[lhbp_pkg::PC_INDEX_BITS-1:0];
						kind_q    <= kind;
						outcome_q <= outcome;
						state_q   <= S_HRD;
					end
				end
				S_HRD: begin
					hist_q  <= h_rdata;
					state_q <= S_CRD;
				end
				S_CRD: begin
					if (finish) begin
						out_valid     <= 1'b1;
						predict_taken <= upd.taken;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted item always moves on to its history read.
	`LHBP_ASSERT_NEXT(a_accept_to_hrd, clk, arst_n, in_accept, state_q == S_HRD,
		"accepted item did not start its history read")
	// Finishing an item always presents a result in the next cycle.
	`LHBP_ASSERT_NEXT(a_finish_result, clk, arst_n, finish, out_valid,
		"finished item left no result")
	// Outside the clearing pass, table writes happen only at write-back of a train item.
	`LHBP_ASSERT_NOW(a_write_only_train, clk, arst_n, (h_we || c_we) && !clearing,
		finish && kind_q, "table write outside train write-back")
	// The counter read address is the history word fetched for this item.
	`LHBP_ASSERT_NEXT(a_ctr_addr, clk, arst_n, c_re, hist_q == $past(h_rdata),
		"counter address differs from fetched history")

endmodule
